[sv/permutation_rank_mod_defines.svh]
// Assertion macros shared by the permutation rank design.
`ifndef PERMUTATION_RANK_MOD_DEFINES_SVH
`define PERMUTATION_RANK_MOD_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define PRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/prm_pkg.sv]
// Constants, tables and helper functions for the permutation rank block.
`default_nettype none

package prm_pkg;

  localparam int unsigned PermMax  = 64;
  localparam int unsigned LenW     = 7;
  localparam int unsigned RankW    = 30;
  localparam int unsigned IdxW     = (PermMax > 1) ? $clog2(PermMax) : 1;
  localparam int unsigned SumW     = $clog2(PermMax + 1);
  localparam int unsigned GrpW     = 8;
  localparam int unsigned NumGrp   = (PermMax + GrpW - 1) / GrpW;
  localparam int unsigned GrpCntW  = $clog2(GrpW + 1);
  localparam int unsigned ProdW    = RankW + LenW;
  // 2**EstShift stays below the modulus, so the table quotient is short by at most one.
  localparam int unsigned EstShift = 29;
  localparam int unsigned EstW     = ProdW - EstShift;
  localparam int unsigned EstDepth = 2 ** EstW;

  localparam logic [RankW-1:0] RankMod  = 30'd998244353;
  localparam logic [LenW-1:0]  LenReset = 7'd8;

  typedef logic [ProdW-1:0] est_table_t [EstDepth];

  // Entry t holds floor(t * 2**EstShift / RankMod) * RankMod.
  function automatic est_table_t build_est_table();
    est_table_t      tbl;
    longint unsigned quo;
    for (int i = 0; i < EstDepth; i++) begin
      quo    = (longint'(i) << EstShift) / RankMod;
      tbl[i] = ProdW'(quo * RankMod);
    end
    return tbl;
  endfunction

  localparam est_table_t EstTable = build_est_table();

  function automatic logic [GrpCntW-1:0] grp_count(logic [GrpW-1:0] bits);
    logic [GrpCntW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < GrpW; i++) begin
      cnt = cnt + GrpCntW'(bits[i]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

[sv/permutation_rank_mod.sv]
// A result is registered after the last element passes stage one and stage two.
// Throughput: one element per cycle while in_stall_o is low; the accumulator loop
// (multiply-add and table-assisted reduction modulo 998244353) closes combinationally.
// Elements pass two register stages (group popcounts, then the smaller-unseen count).
// Reset is asynchronous and active low: length returns to 8 and control state clears.
`default_nettype none
`include "permutation_rank_mod_defines.svh"

module permutation_rank_mod import prm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             perm_length_we_i,
  input  wire logic [LenW-1:0]  perm_length_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [LenW-1:0]  element_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [RankW-1:0]      rank_o,
  output logic                  invalid_o
);

  // Permutation state.
  logic [LenW-1:0]    len_q, len_d;
  logic [PermMax-1:0] seen_q, seen_d;
  logic [LenW-1:0]    pos_q, pos_d;
  logic               err_q, err_d;
  logic [RankW-1:0]   acc_q, acc_d;

  // Stage one: per-group counts of smaller seen values.
  logic               s1_vld_q, s1_vld_d;
  logic [GrpCntW-1:0] s1_grp_q [NumGrp];
  logic [IdxW-1:0]    s1_idx_q;
  logic               s1_good_q;
  logic [LenW-1:0]    s1_mult_q;
  logic               s1_last_q;
  logic               s1_err_q;

  // Stage two: count of smaller values still to come.
  logic               s2_vld_q, s2_vld_d;
  logic [IdxW-1:0]    s2_cnt_q;
  logic [LenW-1:0]    s2_mult_q;
  logic               s2_last_q;
  logic               s2_err_q;

  // Result register.
  logic               out_vld_q, out_vld_d;
  logic [RankW-1:0]   out_rank_q;
  logic               out_inv_q;

  logic out_blocked, s2_go, s2_free, s1_go, s1_free, in_fire;

  assign out_blocked = out_vld_q && out_stall_i;
  assign s2_go       = s2_vld_q && !(s2_last_q && out_blocked);
  assign s2_free     = !s2_vld_q || s2_go;
  assign s1_go       = s1_vld_q && s2_free;
  assign s1_free     = !s1_vld_q || s1_go;
  assign in_stall_o  = !s1_free;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Element checks and the masked view of seen values.
  logic [LenW-1:0]          val_m1;
  logic [IdxW-1:0]          idx;
  logic [PermMax-1:0]       bit_vec;
  logic [PermMax-1:0]       below;
  logic [NumGrp*GrpW-1:0]   below_pad;
  logic                     in_range, good;
  logic [LenW-1:0]          pos_inc, mult;
  logic                     last;
  logic [GrpCntW-1:0]       grp_cnt [NumGrp];

  always_comb begin
    val_m1    = element_value_i - LenW'(1);
    idx       = val_m1[IdxW-1:0];
    bit_vec   = PermMax'(1) << idx;
    below     = seen_q & ~({PermMax{1'b1}} << idx);
    below_pad = (NumGrp*GrpW)'(below);
    in_range  = (element_value_i != '0) && (element_value_i <= len_q);
    good      = in_range && ((seen_q & bit_vec) == '0);
    pos_inc   = pos_q + LenW'(1);
    last      = pos_inc >= len_q;
    mult      = (len_q > pos_q) ? (len_q - pos_q) : LenW'(1);
    for (int g = 0; g < NumGrp; g++) begin
      grp_cnt[g] = grp_count(below_pad[g*GrpW +: GrpW]);
    end
  end

  // Stage two arithmetic.
  logic [SumW-1:0] grp_sum;
  logic [IdxW-1:0] cnt;

  always_comb begin
    grp_sum = '0;
    for (int g = 0; g < NumGrp; g++) begin
      grp_sum = grp_sum + SumW'(s1_grp_q[g]);
    end
    cnt = s1_good_q ? (s1_idx_q - IdxW'(grp_sum)) : '0;
  end

  // Horner step: r = (r * mult + count) mod RankMod, quotient estimated from a table.
  logic [ProdW-1:0] prod, est, rem;
  logic [RankW-1:0] r_new;

  always_comb begin
    prod  = ProdW'(acc_q) * ProdW'(s2_mult_q) + ProdW'(s2_cnt_q);
    est   = EstTable[prod[ProdW-1:EstShift]];
    rem   = prod - est;
    r_new = (rem >= ProdW'(RankMod)) ? RankW'(rem - ProdW'(RankMod)) : RankW'(rem);
  end

  // Next-state logic for control and accumulated state.
  always_comb begin
    len_d     = len_q;
    seen_d    = seen_q;
    pos_d     = pos_q;
    err_d     = err_q;
    acc_d     = acc_q;
    s1_vld_d  = in_fire || (s1_vld_q && !s1_go);
    s2_vld_d  = s1_go || (s2_vld_q && !s2_go);
    out_vld_d = (out_vld_q && out_stall_i) || (s2_go && s2_last_q);

    if (perm_length_we_i) begin
      priority if (perm_length_i == '0) begin
        len_d = LenW'(1);
      end else if (perm_length_i > LenW'(PermMax)) begin
        len_d = LenW'(PermMax);
      end else begin
        len_d = perm_length_i;
      end
      seen_d = '0;
      pos_d  = '0;
      err_d  = 1'b0;
      acc_d  = '0;
    end else begin
      if (in_fire) begin
        if (last) begin
          seen_d = '0;
          pos_d  = '0;
          err_d  = 1'b0;
        end else begin
          seen_d = good ? (seen_q | bit_vec) : seen_q;
          pos_d  = pos_inc;
          err_d  = err_q || !good;
        end
      end
      if (s2_go) begin
        acc_d = s2_last_q ? '0 : r_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LenReset;
      seen_q    <= '0;
      pos_q     <= '0;
      err_q     <= 1'b0;
      acc_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      seen_q    <= seen_d;
      pos_q     <= pos_d;
      err_q     <= err_d;
      acc_q     <= acc_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers load on their stage's advance and need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_grp_q  <= grp_cnt;
      s1_idx_q  <= idx;
      s1_good_q <= good;
      s1_mult_q <= mult;
      s1_last_q <= last;
      s1_err_q  <= err_q || !good;
    end
    if (s1_go) begin
      s2_cnt_q  <= cnt;
      s2_mult_q <= s1_mult_q;
      s2_last_q <= s1_last_q;
      s2_err_q  <= s1_err_q;
    end
    if (s2_go && s2_last_q) begin
      out_rank_q <= r_new;
      out_inv_q  <= s2_err_q;
    end
  end

  // The rank is one-based, so the stored remainder is bumped by one with wraparound.
  assign out_valid_o = out_vld_q;
  assign rank_o      = (out_rank_q == RankMod - RankW'(1)) ? '0 : out_rank_q + RankW'(1);
  assign invalid_o   = out_inv_q;

  `PRM_ASSERT(acc_in_range_a, acc_q < RankMod, "accumulator left the residue range")
  `PRM_ASSERT(pos_below_len_a, pos_q < len_q, "position reached the permutation length")
  `PRM_ASSERT(out_in_range_a, !out_vld_q || (out_rank_q < RankMod), "result beat out of range")
  `PRM_ASSERT(seen_le_pos_a, $countones(seen_q) <= int'(pos_q), "more seen values than positions")
  `PRM_ASSERT_NEXT(last_held_a, s2_vld_q && s2_last_q && out_vld_q && out_stall_i,
                   s2_vld_q && s2_last_q, "final element lost while the result beat waits")

endmodule

`default_nettype wire

[tb/sv/perm_rank_check.sv]
// Watches the permutation rank ports, predicts every rank beat and compares it.
module perm_rank_check import prm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             len_we_i,
  input  wire logic [LenW-1:0]  len_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [LenW-1:0]  element_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic [RankW-1:0] rank_i,
  input  wire logic             invalid_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o,
  output int unsigned           ranks_o,
  output int unsigned           invalid_ranks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             invalid;
  } rank_beat_t;

  rank_beat_t         expected_ranks[$];
  logic [LenW-1:0]    length_q;
  logic [PermMax-1:0] seen_q;
  logic [RankW-1:0]   horner_q;
  logic [LenW-1:0]    taken_q;
  logic               bad_q;
  int unsigned        mismatches    = 0;
  int unsigned        ranks         = 0;
  int unsigned        invalid_ranks = 0;

  task automatic restart_perm();
    seen_q   = '0;
    horner_q = '0;
    taken_q  = '0;
    bad_q    = 1'b0;
  endtask

  // Folds one element into the running rank and queues the rank once the
  // permutation is complete.
  task automatic take_element(input logic [LenW-1:0] v);
    int unsigned        n;
    int unsigned        smaller;
    int unsigned        mult;
    longint unsigned    sum;
    logic [PermMax-1:0] below;
    n = int'(length_q);
    if (n < 1) n = 1;
    if (n > PermMax) n = PermMax;
    smaller = 0;
    if (v == '0 || v > n || seen_q[v - 1]) begin
      bad_q = 1'b1;
    end else begin
      below         = seen_q & ((PermMax'(1) << (v - 1)) - 1'b1);
      smaller       = int'(v) - 1 - $countones(below);
      seen_q[v - 1] = 1'b1;
    end
    mult     = (n > taken_q) ? n - taken_q : 1;
    sum      = 64'(horner_q) * 64'(mult) + 64'(smaller);
    horner_q = RankW'(sum % RankMod);
    taken_q  = taken_q + 1'b1;
    if (taken_q >= n) begin
      expected_ranks.push_back(rank_beat_t'{
        rank:    RankW'((64'(horner_q) + 1) % RankMod),
        invalid: bad_q
      });
      restart_perm();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rank_beat_t want;
    if (!rst_ni) begin
      length_q = LenReset;
      restart_perm();
      expected_ranks.delete();
    end else begin
      // A length write also abandons any permutation in progress.
      if (len_we_i) begin
        length_q = len_i;
        restart_perm();
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_ranks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected rank beat: expected none, actual rank %0d invalid %0b",
                   $time, rank_i, invalid_i);
        end else begin
          want = expected_ranks.pop_front();
          ranks++;
          if (want.invalid) invalid_ranks++;
          if (rank_i !== want.rank) begin
            mismatches++;
            $display("%0t: rank mismatch: expected %0d, actual %0d",
                     $time, want.rank, rank_i);
          end
          if (invalid_i !== want.invalid) begin
            mismatches++;
            $display("%0t: invalid flag mismatch: expected %0b, actual %0b",
                     $time, want.invalid, invalid_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_element(element_i);
      end
    end
    pending_o       <= expected_ranks.size();
    mismatches_o    <= mismatches;
    ranks_o         <= ranks;
    invalid_ranks_o <= invalid_ranks;
  end

endmodule

[tb/sv/permutation_rank_mod_tb.sv]
// Testbench top for permutation_rank_mod: clock, reset, stimulus and the verdict.
module permutation_rank_mod_tb import prm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriodNs  = 6;
  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned RandomItems   = 380;
  localparam int unsigned QuietItems    = 80;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned PressureItems = 40;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned TimeoutNs     = 2_000_000;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             perm_length_we_i = 1'b0;
  logic [LenW-1:0]  perm_length_i    = LenReset;
  logic             in_valid_i       = 1'b0;
  logic [LenW-1:0]  element_value_i  = '0;
  logic             out_stall_i      = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [RankW-1:0] rank_o;
  logic             invalid_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned ranks;
  int unsigned invalid_ranks;
  int unsigned elements_sent = 0;
  int unsigned length_writes = 0;
  bit          quiet         = 1'b0;
  bit          hold_req      = 1'b0;
  bit          hold_started  = 1'b0;

  always #(HalfPeriodNs) clk_i = ~clk_i;

  permutation_rank_mod i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .perm_length_we_i (perm_length_we_i),
    .perm_length_i    (perm_length_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .element_value_i  (element_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rank_o           (rank_o),
    .invalid_o        (invalid_o)
  );

  perm_rank_check i_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .len_we_i        (perm_length_we_i),
    .len_i           (perm_length_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .element_i       (element_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rank_i          (rank_o),
    .invalid_i       (invalid_o),
    .pending_o       (pending),
    .mismatches_o    (mismatches),
    .ranks_o         (ranks),
    .invalid_ranks_o (invalid_ranks)
  );

  task automatic send_element(input logic [LenW-1:0] v);
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    elements_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(5, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every predicted rank has come out, then lets
  // any elements still in the pipeline settle.
  task automatic wait_for_ranks();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LenW-1:0] len);
    perm_length_we_i <= 1'b1;
    perm_length_i    <= len;
    @(posedge clk_i);
    perm_length_we_i <= 1'b0;
    @(posedge clk_i);
    length_writes++;
  endtask

  // Sends the first cut elements of a shuffled permutation of 1..n, with one
  // element optionally replaced by zero, an out-of-range value or a repeat.
  task automatic send_perm(input int unsigned n, input bit corrupt, input int unsigned cut);
    logic [LenW-1:0] vals [PermMax];
    logic [LenW-1:0] t;
    int unsigned     j;
    int unsigned     k;
    for (int i = 0; i < n; i++) vals[i] = LenW'(i + 1);
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      t       = vals[i];
      vals[i] = vals[j];
      vals[j] = t;
    end
    if (corrupt) begin
      k = $urandom_range(n - 1, 0);
      case ($urandom_range(2, 0))
        0: vals[k] = '0;
        1: vals[k] = LenW'($urandom_range(127, n + 1));
        default: vals[k] = vals[$urandom_range(n - 1, 0)];
      endcase
    end
    for (int i = 0; i < cut; i++) begin
      send_element(vals[i]);
      sender_gap();
    end
  endtask

  initial begin : rx_pacing
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_started = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(3, 0) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(16, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(24, 1)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("%0t: run timed out with %0d ranks outstanding", $time, pending);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [LenW-1:0] len;
    int unsigned     n;
    int unsigned     stop_at;
    int unsigned     budget;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset leaves the length at eight: first and last ranks of that length.
    for (int i = 1; i <= 8; i++) send_element(LenW'(i));
    for (int i = 8; i >= 1; i--) send_element(LenW'(i));
    wait_for_ranks();
    write_length(LenW'(1));
    send_element(LenW'(1));
    send_element('0);
    send_element('1);
    wait_for_ranks();
    // A length of zero behaves as a length of one.
    write_length('0);
    send_element(LenW'(1));
    wait_for_ranks();
    write_length(LenW'(3));
    send_element(LenW'(2));
    send_element(LenW'(2));
    send_element(LenW'(1));
    // This permutation is left unfinished; the next length write abandons it.
    send_element(LenW'(3));
    send_element(LenW'(1));
    wait_for_ranks();

    // Pairs keep coming while the receiver holds off, so the block backs up.
    write_length(LenW'(2));
    hold_req = 1'b1;
    wait (hold_started);
    for (int i = 0; i < PressureItems; i++) send_element(LenW'($urandom_range(2, 1)));
    wait_for_ranks();

    len = '1;
    write_length(len);
    stop_at = elements_sent + RandomItems;
    while (elements_sent < stop_at) begin
      n = int'(len);
      if (n == 0) n = 1;
      if (n > PermMax) n = PermMax;
      budget = elements_sent + $urandom_range(70, 30);
      do begin
        quiet = (elements_sent + QuietItems >= stop_at);
        send_perm(n, $urandom_range(7, 0) == 0, n);
      end while (elements_sent < budget && elements_sent < stop_at);
      if (n > 1 && $urandom_range(2, 0) == 0) begin
        send_perm(n, $urandom_range(1, 0), $urandom_range(n - 1, 1));
      end
      wait_for_ranks();
      case ($urandom_range(11, 0))
        0: len = LenW'(PermMax);
        1: len = LenW'($urandom_range(127, PermMax + 1));
        2: len = '0;
        default: len = LenW'($urandom_range(12, 1));
      endcase
      write_length(len);
    end

    wait_for_ranks();
    $display("Sent %0d elements across %0d length writes, with a %0d-cycle output hold.",
             elements_sent, length_writes, HoldCycles);
    $display("Checked %0d ranks, %0d of them flagged invalid.", ranks, invalid_ranks);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/prm_pkg.sv
sv/permutation_rank_mod.sv
tb/sv/perm_rank_check.sv
tb/sv/permutation_rank_mod_tb.sv
